// ===== sv/smx_pkg.sv =====
// Shared types, widths and the exponential table function for the softmax row normalizer.
// Used by every module of the block except smx_ram; depends on nothing.
`default_nettype none
package smx_pkg;

  localparam int ROW_MAX_DEF   = 64;
  localparam int EXP_DEPTH_DEF = 4096;
  localparam int VAL_W  = 16;
  localparam int PROB_W = 16;
  localparam int EXP_W  = 17;  // 0..65536
  localparam int SUM_W  = 23;  // up to 64 * 65536
  localparam int DIV_STEPS = 17;
  localparam int DCNT_W = 5;
  localparam int U_W = 20;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    row_end;
  } smx_in_t;

  typedef struct packed {
    logic [PROB_W-1:0] probability;
    logic              last_of_row;
    logic              overflowed;
  } smx_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SUM_RD, ST_SUM_IDX, ST_SUM_ACC,
    ST_NRM_RD, ST_NRM_IDX, ST_NRM_EXP, ST_DIV, ST_EMIT
  } smx_state_t;

  typedef struct packed {
    logic load;
    logic row_clr;
    logic idx_clr;
    logic idx_inc;
    logic sum_clr;
    logic sum_acc;
    logic div_load;
    logic div_step;
  } smx_cmd_t;

  typedef struct packed {
    logic idx_last;
    logic div_last;
  } smx_status_t;

  // exp(-u / 65536) as Q1.16, built as a product of rounded Q0.32 factors.
  function automatic logic [EXP_W-1:0] exp_from_u(input logic [U_W-1:0] u);
    logic [63:0] fac [U_W];
    logic [63:0] acc;
    logic [63:0] rnd;
    rnd = 64'd1 << 31;
    fac[0] = 64'd4294901760;
    for (int k = 1; k < U_W; k++) begin
      fac[k] = (fac[k-1] * fac[k-1] + rnd) >> 32;
    end
    acc = 64'd1 << 32;
    for (int k = 0; k < U_W; k++) begin
      if (u[k]) begin
        acc = (acc * fac[k] + rnd) >> 32;
      end
    end
    acc = (acc + 64'd32768) >> 16;
    return acc[EXP_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== sv/smx_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
`default_nettype none
module smx_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/smx_exp_rom.sv =====
// Exponential lookup table with registered read; contents fixed at elaboration.
// Depends on smx_pkg for the entry function.
`default_nettype none
module smx_exp_rom
  import smx_pkg::*;
#(
  parameter int EXP_TABLE_DEPTH = EXP_DEPTH_DEF,
  localparam int AW = $clog2(EXP_TABLE_DEPTH)
) (
  input  wire logic             clk,
  input  wire logic [AW-1:0]    addr,
  output logic      [EXP_W-1:0] data
);
  logic [EXP_W-1:0] entries [EXP_TABLE_DEPTH];

  for (genvar i = 0; i < EXP_TABLE_DEPTH; i++) begin : g_entry
    localparam logic [U_W-1:0] U = U_W'((64'(i) << U_W) / EXP_TABLE_DEPTH);
    assign entries[i] = exp_from_u(U);
  end

  always_ff @(posedge clk) begin
    data <= entries[addr];
  end
endmodule
`default_nettype wire

// ===== sv/smx_ctrl.sv =====
// Sequencer for the load, exponent-sum and normalize passes.
// Depends on smx_pkg for the state, command and status types.
`default_nettype none
module smx_ctrl
  import smx_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        row_end,
  input  wire smx_status_t status,
  output smx_cmd_t         cmd,
  output logic             busy,
  output logic             strobe
);
  smx_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    strobe = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          if (row_end) begin
            cmd.sum_clr = 1'b1;
            cmd.idx_clr = 1'b1;
            state_next = ST_SUM_RD;
          end
        end
      end
      ST_SUM_RD:  state_next = ST_SUM_IDX;
      ST_SUM_IDX: state_next = ST_SUM_ACC;
      ST_SUM_ACC: begin
        cmd.sum_acc = 1'b1;
        if (status.idx_last) begin
          cmd.idx_clr = 1'b1;
        end else begin
          cmd.idx_inc = 1'b1;
        end
        state_next = status.idx_last ? ST_NRM_RD : ST_SUM_RD;
      end
      ST_NRM_RD:  state_next = ST_NRM_IDX;
      ST_NRM_IDX: state_next = ST_NRM_EXP;
      ST_NRM_EXP: begin
        cmd.div_load = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        strobe = 1'b1;
        if (status.idx_last) begin
          cmd.row_clr = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next = ST_NRM_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== sv/smx_datapath.sv =====
// Row buffer, running maximum, exponent sum and bit-serial divider.
// Depends on smx_pkg, smx_ram and smx_exp_rom.
`default_nettype none
module smx_datapath
  import smx_pkg::*;
#(
  parameter int ROW_MAX = ROW_MAX_DEF,
  parameter int EXP_TABLE_DEPTH = EXP_DEPTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire smx_cmd_t cmd,
  input  wire smx_in_t  item,
  output smx_status_t   status,
  output smx_out_t      result
);
  localparam int IW = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
  localparam int CW = $clog2(ROW_MAX + 1);
  localparam int AW = $clog2(EXP_TABLE_DEPTH);
  localparam int PW = 12 + 17;

  logic [CW-1:0] count;
  logic [IW-1:0] idx;
  logic signed [VAL_W-1:0] running_max;
  logic overflow_seen;
  logic [SUM_W-1:0] sum;
  logic [VAL_W-1:0] ram_q;
  logic [EXP_W-1:0] rom_q;
  logic far_off;
  logic [16:0] diff;
  logic [PW-1:0] prod;
  logic [AW-1:0] rom_addr;
  logic [EXP_W-1:0] e_val;
  logic store;
  logic [SUM_W:0] rem;
  logic [SUM_W:0] trial;
  logic [DIV_STEPS-1:0] quo;
  logic [DIV_STEPS-1:0] feed;
  logic [DCNT_W-1:0] dcnt;

  assign store = cmd.load && (count < CW'(ROW_MAX));

  smx_ram #(.WIDTH(VAL_W), .DEPTH(ROW_MAX)) u_row_buf (
    .clk(clk), .we(store), .waddr(count[IW-1:0]), .wdata(item.value),
    .raddr(idx), .rdata(ram_q)
  );

  // max - x is never negative; from 16.0 on the exponential is taken as zero.
  assign diff = {running_max[VAL_W-1], running_max} - {ram_q[VAL_W-1], ram_q};
  assign prod = PW'(diff[11:0]) * PW'(EXP_TABLE_DEPTH);
  assign rom_addr = prod[12 +: AW];

  smx_exp_rom #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_exp_rom (
    .clk(clk), .addr(rom_addr), .data(rom_q)
  );

  assign e_val = far_off ? '0 : rom_q;
  assign trial = {rem[SUM_W-1:0], feed[DIV_STEPS-1]};

  always_ff @(posedge clk) begin
    far_off <= (diff[16:12] != 5'd0);
    if (rst || cmd.row_clr) begin
      count <= '0;
      running_max <= {1'b1, {(VAL_W-1){1'b0}}};
      overflow_seen <= 1'b0;
    end else if (cmd.load) begin
      if (store) begin
        count <= count + CW'(1);
        if (item.value > running_max) begin
          running_max <= item.value;
        end
      end else begin
        overflow_seen <= 1'b1;
      end
    end
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + IW'(1);
    end
    if (cmd.sum_clr) begin
      sum <= '0;
    end else if (cmd.sum_acc) begin
      sum <= sum + SUM_W'(e_val);
    end
    // Quotient of (e << 16) / sum; the upper bits of e start as the remainder.
    if (cmd.div_load) begin
      rem <= (SUM_W+1)'(e_val[EXP_W-1:1]);
      feed <= {e_val[0], {(DIV_STEPS-1){1'b0}}};
      quo <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, sum}) begin
        rem <= trial - {1'b0, sum};
        quo <= {quo[DIV_STEPS-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[DIV_STEPS-2:0], 1'b0};
      end
      feed <= {feed[DIV_STEPS-2:0], 1'b0};
      dcnt <= dcnt + DCNT_W'(1);
    end
  end

  assign status.idx_last = ((CW'(idx) + CW'(1)) == count);
  assign status.div_last = (dcnt == DCNT_W'(DIV_STEPS - 1));

  assign result.probability = quo[DIV_STEPS-1] ? {PROB_W{1'b1}} : quo[PROB_W-1:0];
  assign result.last_of_row = status.idx_last;
  assign result.overflowed  = overflow_seen;
endmodule
`default_nettype wire

// ===== sv/softmax_row_normalizer.sv =====
// Row-wise fixed-point softmax.
// Input transfer: start high while busy is low takes one item (signed Q7.8 value and a
// row_end mark). Items are stored in a row buffer of ROW_MAX entries; extra items are
// dropped and every result of that row carries overflowed.
// An item with row_end starts processing and busy stays high until the row's last
// result has gone out. Each result appears for exactly one cycle with strobe high;
// the receiver cannot stall, so results are never held.
// Timing: one element per cycle while loading. After row_end, the exponent-sum pass
// handles each element in turn (buffer read, table read, accumulate) and the normalize
// pass handles each element in turn (buffer read, table read, divider load, a 17-step
// bit-serial divider and the output of its result).
// The divider iterations set the rate.
// Reset (synchronous, rst high) returns to idle with an empty row; the buffer contents
// are not cleared and need not be.
`default_nettype none
module softmax_row_normalizer
  import smx_pkg::*;
#(
  parameter int ROW_MAX = ROW_MAX_DEF,
  parameter int EXP_TABLE_DEPTH = EXP_DEPTH_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire smx_in_t item,
  output logic         busy,
  output logic         strobe,
  output smx_out_t     result
);
  smx_cmd_t    cmd;
  smx_status_t status;

  smx_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .row_end(item.row_end),
    .status(status), .cmd(cmd), .busy(busy), .strobe(strobe)
  );

  smx_datapath #(.ROW_MAX(ROW_MAX), .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_datapath (
    .clk(clk), .rst(rst), .cmd(cmd), .item(item), .status(status), .result(result)
  );
endmodule
`default_nettype wire

// ===== sv/smx_checker.sv =====
// Port-level checks for the softmax row normalizer, bound to the top level.
// Depends on smx_pkg for the payload types.
`default_nettype none
module smx_checker
  import smx_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     start,
  input wire smx_in_t  item,
  input wire logic     busy,
  input wire logic     strobe,
  input wire smx_out_t result
);
  a_reset_idle: assert property (@(posedge clk) rst |=> !busy && !strobe)
    else $error("block not idle after reset");
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst) strobe |-> busy)
    else $error("result transfer while idle");
  a_row_end_busy: assert property (@(posedge clk) disable iff (rst)
      start && !busy && item.row_end |=> busy && !strobe)
    else $error("row end did not start processing");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
      strobe && result.last_of_row |=> !busy)
    else $error("still busy after last result");
  a_strobe_gap: assert property (@(posedge clk) disable iff (rst) strobe |=> !strobe)
    else $error("back-to-back results");
endmodule

bind softmax_row_normalizer smx_checker u_smx_checker (
  .clk(clk), .rst(rst), .start(start), .item(item),
  .busy(busy), .strobe(strobe), .result(result)
);
`default_nettype wire
